// File: design/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg
// shared constants, codes and types of the nearest centroid classifier
// ----------------------------------------------------------------------------
`default_nettype none

package ncc_pkg;

  localparam int MAX_DIMS      = 8;
  localparam int MAX_CENTROIDS = 16;
  localparam int COORD_WIDTH   = 16;

  // leaves of the distance adder tree, unused leaves read as zero
  localparam int TREE_LEAVES = 8;

  localparam int DIFF_W     = COORD_WIDTH + 1;
  localparam int SQ_W       = 2 * COORD_WIDTH;
  localparam int PAIR_W     = SQ_W + 1;
  localparam int QUAD_W     = SQ_W + 2;
  localparam int DIST_W     = SQ_W + 3;
  localparam int ROW_W      = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int ROWS_CNT_W = $clog2(MAX_CENTROIDS + 1);
  localparam int DIMS_CNT_W = $clog2(MAX_DIMS + 1);
  localparam int IDX_W      = 4;
  localparam int ND_W       = 4;
  localparam int NC_W       = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_DIMS      = 1'b0,
    REG_NUM_CENTROIDS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD     = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } func_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // travels alongside one centroid row through the lanes and the merge
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [ROW_W-1:0] row;
  } row_tag_t;

endpackage

`default_nettype wire

// File: design/ncc_lane.sv
// ----------------------------------------------------------------------------
// ncc_lane
// one coordinate lane: difference, then square, two register stages
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_lane
  import ncc_pkg::*;
(
  input  logic            clk,
  input  logic            active,
  input  coord_t          cent,
  input  coord_t          point,
  output logic [SQ_W-1:0] sq
);

  logic signed [DIFF_W-1:0]   diff;
  logic                       active_q;
  logic signed [2*DIFF_W-1:0] prod;

  always_ff @(posedge clk) begin
    diff     <= {cent[COORD_WIDTH-1], cent} - {point[COORD_WIDTH-1], point};
    active_q <= active;
  end

  assign prod = diff * diff;

  // squared magnitude always fits in the low bits
  always_ff @(posedge clk) begin
    sq <= active_q ? prod[SQ_W-1:0] : '0;
  end

endmodule

`default_nettype wire

// File: design/ncc_merge.sv
// ----------------------------------------------------------------------------
// ncc_merge
// sums the lane squares over a registered tree and keeps the best row
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_merge
  import ncc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SQ_W-1:0]   sq [MAX_DIMS],
  input  row_tag_t          tag_in,
  output logic              done,
  output logic [ROW_W-1:0]  best_row,
  output logic [DIST_W-1:0] best_dist
);

  logic [SQ_W-1:0]   leaf [TREE_LEAVES];
  logic [PAIR_W-1:0] pair [TREE_LEAVES/2];
  logic [QUAD_W-1:0] quad [TREE_LEAVES/4];
  logic [DIST_W-1:0] total;
  row_tag_t          tag_pair;
  row_tag_t          tag_quad;

  for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
    if (i < MAX_DIMS) begin : g_used
      assign leaf[i] = sq[i];
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TREE_LEAVES/2; i++) begin
      pair[i] <= PAIR_W'(leaf[2*i]) + PAIR_W'(leaf[2*i+1]);
    end
    for (int i = 0; i < TREE_LEAVES/4; i++) begin
      quad[i] <= QUAD_W'(pair[2*i]) + QUAD_W'(pair[2*i+1]);
    end
  end

  assign total = DIST_W'(quad[0]) + DIST_W'(quad[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_pair <= '0;
      tag_quad <= '0;
      done     <= 1'b0;
    end else begin
      tag_pair <= tag_in;
      tag_quad <= tag_pair;
      done     <= tag_quad.valid && tag_quad.last;
    end
  end

  // strict compare keeps the lowest row on ties
  always_ff @(posedge clk) begin
    if (tag_quad.valid && (tag_quad.first || (total < best_dist))) begin
      best_dist <= total;
      best_row  <= tag_quad.row;
    end
  end

endmodule

`default_nettype wire

// File: design/nearest_centroid_classifier.sv
// ----------------------------------------------------------------------------
// nearest_centroid_classifier
// nearest centroid assignment over a table of loaded centroid rows
// ----------------------------------------------------------------------------
// A load transfer (func = 0) writes all eight coordinates of one centroid row
// and gives no result; the block is ready again on the next cycle. A
// classify transfer (func = 1) sweeps rows 0 .. num_centroids-1, one row
// per cycle through the single read port of the centroid memory, with eight
// coordinate lanes working on that row side by side and a merge stage
// summing their squares and keeping the nearest row. After a classify the
// block takes the next item once the result register is free and has taken
// the result. The result (cluster_index, lowest index on ties, and
// min_distance_sq) sits in an output register, so the next item can come in
// while it waits. Rows that were never loaded hold unknown data and must not
// be searched. num_dims and num_centroids of zero count as one, larger
// values clamp to the maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_centroid_classifier
  import ncc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [IDX_W-1:0]      centroid_index,
  input  coord_t                coord0,
  input  coord_t                coord1,
  input  coord_t                coord2,
  input  coord_t                coord3,
  input  coord_t                coord4,
  input  coord_t                coord5,
  input  coord_t                coord6,
  input  coord_t                coord7,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_W-1:0]      cluster_index,
  output logic [DIST_W-1:0]     min_distance_sq
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [ND_W-1:0] num_dims;
  logic [NC_W-1:0] num_centroids;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims      <= ND_W'(8);
      num_centroids <= NC_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NUM_DIMS:      num_dims      <= cfg_data[ND_W-1:0];
        REG_NUM_CENTROIDS: num_centroids <= cfg_data[NC_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped counts, sampled when a classify comes in
  logic [DIMS_CNT_W-1:0] dims_eff;
  logic [ROWS_CNT_W-1:0] rows_eff_next;
  logic [ROWS_CNT_W-1:0] rows_eff;
  logic [MAX_DIMS-1:0]   lane_mask_next;
  logic [MAX_DIMS-1:0]   lane_mask;

  always_comb begin
    if (num_dims == '0) begin
      dims_eff = DIMS_CNT_W'(1);
    end else if (num_dims > MAX_DIMS) begin
      dims_eff = DIMS_CNT_W'(MAX_DIMS);
    end else begin
      dims_eff = DIMS_CNT_W'(num_dims);
    end
    if (num_centroids == '0) begin
      rows_eff_next = ROWS_CNT_W'(1);
    end else if (num_centroids > MAX_CENTROIDS) begin
      rows_eff_next = ROWS_CNT_W'(MAX_CENTROIDS);
    end else begin
      rows_eff_next = ROWS_CNT_W'(num_centroids);
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      lane_mask_next[d] = DIMS_CNT_W'(d) < dims_eff;
    end
  end

  // input transfer decode
  logic   in_fire;
  logic   load_fire;
  logic   classify_fire;
  coord_t in_coord [MAX_DIMS];
  logic [MAX_DIMS*COORD_WIDTH-1:0] in_word;

  assign in_ready      = (state == S_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign load_fire     = in_fire && (func_t'(func) == FUNC_LOAD);
  assign classify_fire = in_fire && (func_t'(func) == FUNC_CLASSIFY);

  assign in_coord[0] = coord0;
  assign in_coord[1] = coord1;
  assign in_coord[2] = coord2;
  assign in_coord[3] = coord3;
  assign in_coord[4] = coord4;
  assign in_coord[5] = coord5;
  assign in_coord[6] = coord6;
  assign in_coord[7] = coord7;

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      in_word[d*COORD_WIDTH +: COORD_WIDTH] = in_coord[d];
    end
  end

  // centroid memory, one full row per word
  logic [MAX_DIMS*COORD_WIDTH-1:0] mem [MAX_CENTROIDS];
  logic [MAX_DIMS*COORD_WIDTH-1:0] rd_data;
  logic [ROW_W-1:0]                rd_row;
  logic                            load_in_range;

  // loads past the table are dropped
  assign load_in_range = {1'b0, centroid_index} < (IDX_W + 1)'(MAX_CENTROIDS);

  always_ff @(posedge clk) begin
    if (load_fire && load_in_range) begin
      mem[ROW_W'(centroid_index)] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_row];
  end

  // point held for the whole sweep
  coord_t point [MAX_DIMS];

  always_ff @(posedge clk) begin
    if (classify_fire) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        point[d] <= in_coord[d];
      end
      rows_eff  <= rows_eff_next;
      lane_mask <= lane_mask_next;
    end
  end

  // row sweep: issue one row read per cycle
  logic     issue_last;
  row_tag_t tag_issue;
  row_tag_t tag_rd;
  row_tag_t tag_diff;
  row_tag_t tag_sq;

  assign issue_last = (ROWS_CNT_W'(rd_row) + ROWS_CNT_W'(1)) == rows_eff;

  always_comb begin
    tag_issue.valid = (state == S_SWEEP);
    tag_issue.first = (rd_row == '0);
    tag_issue.last  = issue_last;
    tag_issue.row   = rd_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_row <= '0;
    end else if (classify_fire) begin
      rd_row <= '0;
    end else if (state == S_SWEEP) begin
      rd_row <= rd_row + ROW_W'(1);
    end
  end

  // tag follows the memory read and the two lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd   <= '0;
      tag_diff <= '0;
      tag_sq   <= '0;
    end else begin
      tag_rd   <= tag_issue;
      tag_diff <= tag_rd;
      tag_sq   <= tag_diff;
    end
  end

  // coordinate lanes
  logic [SQ_W-1:0] lane_sq [MAX_DIMS];

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
    ncc_lane u_lane (
      .clk    (clk),
      .active (lane_mask[d]),
      .cent   (coord_t'(rd_data[d*COORD_WIDTH +: COORD_WIDTH])),
      .point  (point[d]),
      .sq     (lane_sq[d])
    );
  end

  // merge of lane results, best row so far
  logic              merge_done;
  logic [ROW_W-1:0]  best_row;
  logic [DIST_W-1:0] best_dist;

  ncc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .sq        (lane_sq),
    .tag_in    (tag_sq),
    .done      (merge_done),
    .best_row  (best_row),
    .best_dist (best_dist)
  );

  // control
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (classify_fire) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (merge_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      cluster_index   <= IDX_W'(best_row);
      min_distance_sq <= best_dist;
    end
  end

endmodule

`default_nettype wire

// File: design/ncc_checker.sv
// ----------------------------------------------------------------------------
// ncc_checker
// port level checks of the nearest centroid classifier
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  cluster_index,
  input logic [34:0] min_distance_sq
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cluster_index)
      && $stable(min_distance_sq))
    else $error("result changed while stalled");

  // a classify transfer closes the input side for the start of its sweep
  a_classify_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func |=> !in_ready)
    else $error("input open right after classify transfer");

  // a load never blocks the next item
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !func |=> in_ready)
    else $error("load transfer blocked input");

  // a new result only comes at the end of a classify
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a classify in progress");

endmodule

bind nearest_centroid_classifier ncc_checker u_ncc_checker (.*);

`default_nettype wire
